FILE: design/lwa_pkg.sv
// Shared types and constants for the light window average and shade angle block.
`default_nettype none

package lwa_pkg;

  // Field widths fixed by the item formats.
  localparam int LIGHT_W    = 12;
  localparam int ANGLE_W    = 8;
  localparam int HELD_W     = 8;
  localparam int TEMP_W     = 11;
  localparam int WIN_W      = 8;
  localparam int OFF_W      = 8;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Arithmetic constants of the angle formula.
  localparam int ANGLE_MAX  = 180;
  localparam int FULL_SCALE = 4095;
  localparam int Q_SHIFT    = 20;
  localparam int Q_BIAS     = 256;

  // Register reset values.
  localparam logic [WIN_W-1:0]         WINDOW_RST = 8'd24;
  localparam logic [OFF_W-1:0]         OFFSET_RST = 8'd30;
  localparam logic signed [GAIN_W-1:0] GAIN_RST   = -24'sd8892;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_ANGLE_OFFSET  = 2'd1,
    REG_ANGLE_GAIN    = 2'd2
  } cfg_reg_t;

  // Top level sequencer states.
  typedef enum logic [2:0] {
    T_IDLE,
    T_STORE,
    T_AVG,
    T_ANGLE,
    T_OUT
  } top_state_t;

  // Angle unit states.
  typedef enum logic [2:0] {
    A_IDLE,
    A_SCALE,
    A_GAIN,
    A_MUL,
    A_PREP,
    A_DIV,
    A_FIN
  } ang_state_t;

  // Commands to the sample ring.
  typedef struct packed {
    logic store;
    logic clear;
  } ring_ctl_t;

  // Settings used by the angle unit.
  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [GAIN_W-1:0] gain;
  } ang_cfg_t;

endpackage

`default_nettype wire

FILE: design/lwa_if.sv
// Handshake channel interfaces for input items, result items and register writes.
`default_nettype none

interface lwa_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [lwa_pkg::LIGHT_W-1:0]         light_raw;
  logic signed [lwa_pkg::TEMP_W-1:0]   temperature;

  modport source (output valid, op, light_raw, temperature, input ready);
  modport sink (input valid, op, light_raw, temperature, output ready);
endinterface

interface lwa_out_if;
  logic                          valid;
  logic                          ready;
  logic [lwa_pkg::LIGHT_W-1:0]   average_light;
  logic [lwa_pkg::ANGLE_W-1:0]   shade_angle;
  logic [lwa_pkg::HELD_W-1:0]    samples_held;

  modport source (output valid, average_light, shade_angle, samples_held, input ready);
  modport sink (input valid, average_light, shade_angle, samples_held, output ready);
endinterface

interface lwa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lwa_pkg::CFG_IDX_W-1:0]    index;
  logic [lwa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/lwa_ring.sv
// Sample ring memory with write slot, valid count and running sum.
`default_nettype none

module lwa_ring #(
  parameter int MAX_WINDOW = 128,
  localparam int SLOT_W = $clog2(MAX_WINDOW),
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W  = lwa_pkg::LIGHT_W + CNT_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lwa_pkg::ring_ctl_t            ctl,
  input  wire logic [lwa_pkg::LIGHT_W-1:0]   light,
  input  wire logic [CNT_W-1:0]              win,
  output logic                               done,
  output logic [CNT_W-1:0]                   count,
  output logic [SUM_W-1:0]                   sum
);

  logic [lwa_pkg::LIGHT_W-1:0] ram [MAX_WINDOW];
  logic [lwa_pkg::LIGHT_W-1:0] old_r;
  logic [lwa_pkg::LIGHT_W-1:0] light_r;
  logic [SLOT_W-1:0]           slot_r, slot_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [CNT_W:0]              slot_inc;
  logic                        upd_r;
  logic                        done_r;

  // The oldest sample is read into old_r on a store and then overwritten by the registered update.
  always_ff @(posedge clk) begin
    if (ctl.store) begin
      old_r   <= ram[slot_r];
      light_r <= light;
    end
    if (upd_r) begin
      ram[slot_r] <= light_r;
    end
  end

  // Next slot, count and sum for a store.
  always_comb begin
    slot_inc = (CNT_W + 1)'(slot_r) + (CNT_W + 1)'(1);
    slot_nxt = (slot_inc >= {1'b0, win}) ? '0 : slot_inc[SLOT_W-1:0];
    if (count_r >= win) begin
      sum_nxt   = sum_r - SUM_W'(old_r) + SUM_W'(light_r);
      count_nxt = win;
    end else begin
      sum_nxt   = sum_r + SUM_W'(light_r);
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Window state; a new window length empties the window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
      upd_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      upd_r  <= ctl.store;
      done_r <= upd_r;
      if (ctl.clear) begin
        slot_r  <= '0;
        count_r <= '0;
        sum_r   <= '0;
      end else if (upd_r) begin
        slot_r  <= slot_nxt;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  assign done  = done_r;
  assign count = count_r;
  assign sum   = sum_r;

endmodule

`default_nettype wire

FILE: design/lwa_div.sv
// Restoring divider giving the mean of the window one quotient bit per cycle.
`default_nettype none

module lwa_div #(
  parameter int MAX_WINDOW = 128,
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W  = lwa_pkg::LIGHT_W + CNT_W,
  localparam int STEP_W = $clog2(lwa_pkg::LIGHT_W + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [SUM_W-1:0]              dividend,
  input  wire logic [CNT_W-1:0]              divisor,
  output logic                               done,
  output logic [lwa_pkg::LIGHT_W-1:0]        quot
);

  logic [SUM_W-1:0]            rem_r;
  logic [SUM_W-1:0]            dvs_r;
  logic [lwa_pkg::LIGHT_W-1:0] q_r;
  logic [STEP_W-1:0]           step_r;
  logic                        busy_r;
  logic                        done_r;
  logic                        zero_r;
  logic                        ge;

  // The mean never exceeds the largest sample, so twelve steps suffice.
  assign ge = (rem_r >= dvs_r);

  // Datapath: shifted divisor, partial remainder and quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dvs_r  <= SUM_W'({divisor, {(lwa_pkg::LIGHT_W - 1){1'b0}}});
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      q_r   <= {q_r[lwa_pkg::LIGHT_W-2:0], ge};
      dvs_r <= dvs_r >> 1;
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(lwa_pkg::LIGHT_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // An empty window has a mean of zero.
  assign quot = zero_r ? '0 : q_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: design/lwa_ang.sv
// Shade angle unit: gain products, serial temperature multiply and divide by full scale.
`default_nettype none

module lwa_ang (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [lwa_pkg::LIGHT_W-1:0]          avg,
  input  wire lwa_pkg::ang_cfg_t                    cfg,
  input  wire logic signed [lwa_pkg::TEMP_W-1:0]    temp,
  output logic                                      done,
  output logic [lwa_pkg::ANGLE_W-1:0]               angle
);

  localparam int DIFF_W = lwa_pkg::OFF_W + 1;
  localparam int M1_W   = DIFF_W + lwa_pkg::LIGHT_W + 1;
  localparam int ACC_W  = M1_W + lwa_pkg::GAIN_W + lwa_pkg::TEMP_W;
  localparam int X_W    = ACC_W - lwa_pkg::Q_SHIFT;
  localparam int Y_W    = 21;
  localparam int Q_W    = 9;
  localparam int T_W    = 11;
  localparam int CNT_W  = 4;

  localparam logic signed [X_W-1:0] HI_LIM =
    X_W'(lwa_pkg::FULL_SCALE * (lwa_pkg::ANGLE_MAX + 1));
  localparam logic signed [X_W-1:0] LO_LIM =
    X_W'(-(lwa_pkg::FULL_SCALE * lwa_pkg::Q_BIAS));
  localparam logic signed [X_W-1:0] X_BIAS =
    X_W'(lwa_pkg::FULL_SCALE * lwa_pkg::Q_BIAS);
  localparam logic [Y_W-1:0] DIV_TOP =
    Y_W'(lwa_pkg::FULL_SCALE * (1 << (Q_W - 1)));

  lwa_pkg::ang_state_t state_r, state_nxt;

  logic signed [DIFF_W-1:0]          diff;
  logic signed [lwa_pkg::LIGHT_W:0]  avg_s;
  logic signed [M1_W-1:0]            m1_nxt;
  logic signed [M1_W-1:0]            m1_r;
  logic signed [ACC_W-1:0]           m2_nxt;
  logic signed [ACC_W-1:0]           m2_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [lwa_pkg::TEMP_W-1:0] t_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic signed [X_W-1:0]             x;
  logic signed [X_W-1:0]             x_biased;
  logic                              hi_r, lo_r;
  logic [Y_W-1:0]                    y_r;
  logic [Y_W-1:0]                    dd_r;
  logic [Q_W-1:0]                    q_r;
  logic                              y_ge;
  logic signed [T_W-1:0]             t_sum;
  logic [lwa_pkg::ANGLE_W-1:0]       clamped;
  logic [lwa_pkg::ANGLE_W-1:0]       angle_r;
  logic                              done_r;

  // Products of the first two stages.
  assign diff   = DIFF_W'(lwa_pkg::ANGLE_MAX) - $signed({1'b0, cfg.offset});
  assign avg_s  = $signed({1'b0, avg});
  assign m1_nxt = diff * avg_s;
  assign m2_nxt = m1_r * $signed(cfg.gain);

  // The Q20 floor is the upper part of the product; the clamp range is
  // checked before the constant divide so that it runs on a narrow value.
  assign x        = acc_r[ACC_W-1:lwa_pkg::Q_SHIFT];
  assign x_biased = x + X_BIAS;
  assign y_ge     = (y_r >= dd_r);

  // Offset plus the floored quotient, then clamped to the servo range.
  always_comb begin
    t_sum = $signed({{(T_W - lwa_pkg::OFF_W){1'b0}}, cfg.offset})
          + $signed({{(T_W - Q_W){1'b0}}, q_r})
          - T_W'(lwa_pkg::Q_BIAS);
    if (hi_r) begin
      clamped = lwa_pkg::ANGLE_W'(lwa_pkg::ANGLE_MAX);
    end else if (lo_r || t_sum < 0) begin
      clamped = '0;
    end else if (t_sum > T_W'(lwa_pkg::ANGLE_MAX)) begin
      clamped = lwa_pkg::ANGLE_W'(lwa_pkg::ANGLE_MAX);
    end else begin
      clamped = t_sum[lwa_pkg::ANGLE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lwa_pkg::A_IDLE:  if (start) state_nxt = lwa_pkg::A_SCALE;
      lwa_pkg::A_SCALE: state_nxt = lwa_pkg::A_GAIN;
      lwa_pkg::A_GAIN:  state_nxt = lwa_pkg::A_MUL;
      lwa_pkg::A_MUL:   if (cnt_r == '0) state_nxt = lwa_pkg::A_PREP;
      lwa_pkg::A_PREP:  state_nxt = lwa_pkg::A_DIV;
      lwa_pkg::A_DIV:   if (cnt_r == '0) state_nxt = lwa_pkg::A_FIN;
      lwa_pkg::A_FIN:   state_nxt = lwa_pkg::A_IDLE;
      default:          state_nxt = lwa_pkg::A_IDLE;
    endcase
  end

  // State register and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lwa_pkg::A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == lwa_pkg::A_FIN);
    end
  end

  // Datapath, one step per state.
  always_ff @(posedge clk) begin
    case (state_r)
      lwa_pkg::A_SCALE: begin
        m1_r <= m1_nxt;
      end
      lwa_pkg::A_GAIN: begin
        m2_r  <= m2_nxt;
        acc_r <= '0;
        t_r   <= temp;
        cnt_r <= CNT_W'(lwa_pkg::TEMP_W - 1);
      end
      lwa_pkg::A_MUL: begin
        // Temperature bits LSB first; the sign bit carries negative weight.
        if (t_r[0]) begin
          acc_r <= (cnt_r == '0) ? acc_r - m2_r : acc_r + m2_r;
        end
        m2_r  <= m2_r <<< 1;
        t_r   <= t_r >>> 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      lwa_pkg::A_PREP: begin
        hi_r  <= (x >= HI_LIM);
        lo_r  <= (x < LO_LIM);
        y_r   <= x_biased[Y_W-1:0];
        dd_r  <= DIV_TOP;
        cnt_r <= CNT_W'(Q_W - 1);
      end
      lwa_pkg::A_DIV: begin
        if (y_ge) begin
          y_r <= y_r - dd_r;
        end
        q_r   <= {q_r[Q_W-2:0], y_ge};
        dd_r  <= dd_r >> 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      lwa_pkg::A_FIN: begin
        angle_r <= clamped;
      end
      default: begin
      end
    endcase
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

`default_nettype wire

FILE: design/light_window_average_shade_angle.sv
// Top level: registers, item sequencer and result register of the shade block.
//
// Input items arrive on in_ch. With op low an item stores light_raw in the
// sample ring; with op high it computes the shade angle for temperature.
// Every input item gives exactly one result item on out_ch: the floored mean
// of the window, the angle (0 for a store) and the number of samples held.
// Registers are to be written on cfg_ch only while the block is idle; the block
// itself does not enforce this. Index 0 is the window length (writing it
// empties the window), 1 the angle offset and 2 the Q20 angle gain. cfg_ch is
// always ready. Items are handled one at a time. A store passes through a ring
// read and update, then the twelve-step mean divider, until its result is
// offered. An angle item passes through the mean divider, two multiplies, an
// eleven-step serial multiply by the temperature and a nine-step divide by the
// converter full scale. The next item is accepted once the sequencer is idle
// again after loading the result.
// The result waits in an output register; if the receiver stalls, the block
// stops after finishing the next item until the register is free.
// Reset empties the window and loads the register defaults; the ring itself
// is not cleared, since only written entries are ever read.
`default_nettype none

module light_window_average_shade_angle #(
  parameter int MAX_WINDOW = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lwa_in_if.sink    in_ch,
  lwa_out_if.source out_ch,
  lwa_cfg_if.sink   cfg_ch
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = lwa_pkg::LIGHT_W + CNT_W;

  lwa_pkg::top_state_t state_r, state_nxt;

  logic [lwa_pkg::WIN_W-1:0]         window_length_r;
  logic [lwa_pkg::OFF_W-1:0]         angle_offset_r;
  logic [lwa_pkg::GAIN_W-1:0]        angle_gain_r;
  logic                              op_r;
  logic signed [lwa_pkg::TEMP_W-1:0] temp_r;
  logic                              cfg_we;
  logic                              in_acc;
  logic [CNT_W-1:0]                  eff_win;

  lwa_pkg::ring_ctl_t                ring_ctl;
  lwa_pkg::ang_cfg_t                 ang_cfg;
  logic                              ring_done;
  logic [CNT_W-1:0]                  ring_count;
  logic [SUM_W-1:0]                  ring_sum;
  logic                              div_start, div_done;
  logic [lwa_pkg::LIGHT_W-1:0]       div_quot;
  logic                              ang_start, ang_done;
  logic [lwa_pkg::ANGLE_W-1:0]       ang_angle;
  logic                              out_load;

  logic                              out_valid_r;
  logic [lwa_pkg::LIGHT_W-1:0]       out_avg_r;
  logic [lwa_pkg::ANGLE_W-1:0]       out_angle_r;
  logic [lwa_pkg::HELD_W-1:0]        out_held_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == lwa_pkg::T_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= lwa_pkg::WINDOW_RST;
      angle_offset_r  <= lwa_pkg::OFFSET_RST;
      angle_gain_r    <= lwa_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_ch.index)
        lwa_pkg::REG_WINDOW_LENGTH: window_length_r <= cfg_ch.data[lwa_pkg::WIN_W-1:0];
        lwa_pkg::REG_ANGLE_OFFSET:  angle_offset_r  <= cfg_ch.data[lwa_pkg::OFF_W-1:0];
        lwa_pkg::REG_ANGLE_GAIN:    angle_gain_r    <= cfg_ch.data[lwa_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Window length in use: a zero length counts as one, and it saturates at
  // the ring depth.
  always_comb begin
    if (32'(window_length_r) > 32'(MAX_WINDOW)) begin
      eff_win = CNT_W'(MAX_WINDOW);
    end else if (window_length_r == '0) begin
      eff_win = CNT_W'(1);
    end else begin
      eff_win = CNT_W'(window_length_r);
    end
  end

  assign ang_cfg.offset = angle_offset_r;
  assign ang_cfg.gain   = angle_gain_r;

  // Item sequencer.
  always_comb begin
    state_nxt      = state_r;
    ring_ctl.store = 1'b0;
    ring_ctl.clear = cfg_we && (cfg_ch.index == lwa_pkg::REG_WINDOW_LENGTH);
    div_start      = 1'b0;
    ang_start      = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      lwa_pkg::T_IDLE: begin
        if (in_ch.valid) begin
          if (!in_ch.op) begin
            ring_ctl.store = 1'b1;
            state_nxt      = lwa_pkg::T_STORE;
          end else begin
            div_start = 1'b1;
            state_nxt = lwa_pkg::T_AVG;
          end
        end
      end
      lwa_pkg::T_STORE: begin
        if (ring_done) begin
          div_start = 1'b1;
          state_nxt = lwa_pkg::T_AVG;
        end
      end
      lwa_pkg::T_AVG: begin
        if (div_done) begin
          if (op_r) begin
            ang_start = 1'b1;
            state_nxt = lwa_pkg::T_ANGLE;
          end else begin
            state_nxt = lwa_pkg::T_OUT;
          end
        end
      end
      lwa_pkg::T_ANGLE: begin
        if (ang_done) state_nxt = lwa_pkg::T_OUT;
      end
      lwa_pkg::T_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = lwa_pkg::T_IDLE;
        end
      end
      default: state_nxt = lwa_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lwa_pkg::T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item fields kept for the duration of the work.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_ch.op;
      temp_r <= in_ch.temperature;
    end
  end

  lwa_ring #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .light (in_ch.light_raw),
    .win   (eff_win),
    .done  (ring_done),
    .count (ring_count),
    .sum   (ring_sum)
  );

  lwa_div #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ring_sum),
    .divisor  (ring_count),
    .done     (div_done),
    .quot     (div_quot)
  );

  lwa_ang u_ang (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ang_start),
    .avg   (div_quot),
    .cfg   (ang_cfg),
    .temp  (temp_r),
    .done  (ang_done),
    .angle (ang_angle)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r   <= div_quot;
      out_angle_r <= op_r ? ang_angle : '0;
      out_held_r  <= lwa_pkg::HELD_W'(ring_count);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.average_light = out_avg_r;
  assign out_ch.shade_angle   = out_angle_r;
  assign out_ch.samples_held  = out_held_r;

  // A result only appears after the sequencer has finished an item.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lwa_pkg::T_OUT))
    else $error("result raised outside the output state");

  // An accepted item always starts work.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != lwa_pkg::T_IDLE))
    else $error("accepted item left the sequencer idle");

  // The window never holds more samples than its length.
  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    ring_count <= eff_win)
    else $error("sample count exceeds the window length");

  // The angle unit stays within the servo range.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    ang_done |-> (ang_angle <= lwa_pkg::ANGLE_W'(lwa_pkg::ANGLE_MAX)))
    else $error("shade angle out of range");

endmodule

`default_nettype wire
